// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the frame builder.
// Needs clk and rst_n in scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/gbfb_pkg.sv
// Package of the GNSS binary frame builder: constants, command codes and
// the queue entry passed from front to back. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbfb_pkg;

    localparam logic [7:0] SYNC_ONE        = 8'hB5;
    localparam logic [7:0] SYNC_TWO        = 8'h62;
    localparam int         MAX_PAYLOAD_DEF = 20;
    localparam int         QUEUE_DEPTH_DEF = 4;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    // One unit of back-end work: a frame header or one payload byte,
    // with the running checksum attached when the frame closes on it.
    typedef struct packed
    {
        cmd_t       kind;
        logic [7:0] b0;     // class, or the payload byte
        logic [7:0] b1;     // id
        logic [7:0] b2;     // length low byte
        logic       last;   // checksum follows
        logic [7:0] ck_a;
        logic [7:0] ck_b;
    } entry_t;

endpackage

`default_nettype wire

// File: hdl/gbfb_in_if.sv
// Input channel of the frame builder: valid/ready plus command fields.
// Stand-alone, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gbfb_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] msg_class;
    logic [7:0] msg_id;
    logic [7:0] payload_length;
    logic [7:0] data_byte;

    modport source (output valid, command, msg_class, msg_id, payload_length, data_byte,
                    input ready);
    modport sink   (input valid, command, msg_class, msg_id, payload_length, data_byte,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/gbfb_out_if.sv
// Output channel of the frame builder: valid/ready plus one frame byte.
// Stand-alone, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gbfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_frame;

    modport source (output valid, out_byte, end_of_frame, input ready);
    modport sink   (input valid, out_byte, end_of_frame, output ready);
endinterface

`default_nettype wire

// File: hdl/gnss_binary_frame_builder_top.sv
// GNSS binary frame builder, top level: front end, entry queue, back end.
// Depends on gbfb_pkg, gbfb_in_if, gbfb_out_if and the three sub-blocks.
//
// Usage: words on the item channel either open a frame (command 0, with
// class, id and payload length) or carry one payload byte (command 1).
// The stream channel gives the frame byte by byte: sync 0xB5 0x62, class,
// id, length low, length high (zero), the payload, then CK_A and CK_B,
// with end_of_frame set on CK_B. A zero-length start gives all 8 bytes.
// A start longer than MAX_PAYLOAD, or a payload word outside a frame, is
// taken and dropped. A new start abandons an unfinished frame without its checksum.
// An accepted word is written into the queue, and its first byte is then
// registered in the output stage. Throughput: the back end sends one byte per
// cycle while the stream is not stalled; a payload word gives one byte (three on
// the closing word), a start six (eight for an empty frame). The item channel
// takes a word every cycle while the QUEUE_DEPTH-entry queue has room, so header
// and checksum bursts stall it only once the queue fills.
// Reset clears the frame state, the queue and the output stage; nothing
// is sent until a start arrives. A stalled stream holds its byte steady
// and lets the queue fill, after which item.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_builder_top
    import gbfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input wire logic   clk,
    input wire logic   rst_n,
    gbfb_in_if.sink    item,
    gbfb_out_if.source stream
);

    // Front to queue
    logic   push;
    entry_t push_entry;
    logic   q_full;

    // Queue to back
    entry_t head;
    logic   q_empty;
    logic   pop;

    gbfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (item.valid),
        .in_ready       (item.ready),
        .command        (item.command),
        .msg_class      (item.msg_class),
        .msg_id         (item.msg_id),
        .payload_length (item.payload_length),
        .data_byte      (item.data_byte),
        .q_full         (q_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    gbfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Back end drives the registered output stage directly.
    gbfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (stream.valid),
        .out_ready (stream.ready),
        .out_byte  (stream.out_byte),
        .out_eof   (stream.end_of_frame)
    );

endmodule

`default_nettype wire

// File: hdl/gbfb_front.sv
// Front end: accepts words, tracks the frame and the Fletcher sums,
// pushes one entry per useful word. Depends on gbfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfb_front
    import gbfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire logic   command,
    input  wire logic [7:0] msg_class,
    input  wire logic [7:0] msg_id,
    input  wire logic [7:0] payload_length,
    input  wire logic [7:0] data_byte,
    input  wire logic   q_full,
    output logic        push,
    output entry_t      push_entry
);

    localparam int BL_W = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]      sum_a_reg, sum_a_next;
    logic [7:0]      sum_b_reg, sum_b_next;
    logic [BL_W-1:0] bytes_left_reg, bytes_left_next;
    logic            in_frame_reg, in_frame_next;

    logic       accept;
    logic       len_ok;
    logic [7:0] a2, a3, b2, b3, b4;
    logic [7:0] da, db;
    logic       data_last;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign len_ok   = {1'b0, payload_length} <= 9'(MAX_PAYLOAD);

    // Header sums from zero over class, id, length low, length high (zero).
    assign a2 = msg_class + msg_id;
    assign b2 = msg_class + a2;
    assign a3 = a2 + payload_length;
    assign b3 = b2 + a3;
    assign b4 = b3 + a3;

    assign da        = sum_a_reg + data_byte;
    assign db        = sum_b_reg + da;
    assign data_last = bytes_left_reg == BL_W'(1);

    always_comb
    begin
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        bytes_left_next = bytes_left_reg;
        in_frame_next   = in_frame_reg;
        push            = 1'b0;
        push_entry      = '{kind: CMD_START, b0: msg_class, b1: msg_id,
                            b2: payload_length, last: 1'b0, ck_a: a3, ck_b: b4};
        if (accept)
        begin
            unique case (cmd_t'(command))
                CMD_START:
                begin
                    if (len_ok)
                    begin
                        push            = 1'b1;
                        push_entry.last = payload_length == 8'd0;
                        sum_a_next      = a3;
                        sum_b_next      = b4;
                        bytes_left_next = payload_length[BL_W-1:0];
                        in_frame_next   = payload_length != 8'd0;
                    end
                end
                CMD_DATA:
                begin
                    if (in_frame_reg)
                    begin
                        push            = 1'b1;
                        push_entry      = '{kind: CMD_DATA, b0: data_byte, b1: 8'd0,
                                            b2: 8'd0, last: data_last, ck_a: da, ck_b: db};
                        sum_a_next      = da;
                        sum_b_next      = db;
                        bytes_left_next = bytes_left_reg - BL_W'(1);
                        in_frame_next   = !data_last;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            bytes_left_reg <= '0;
            in_frame_reg   <= 1'b0;
        end
        else
        begin
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            bytes_left_reg <= bytes_left_next;
            in_frame_reg   <= in_frame_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/gbfb_queue.sv
// Small register queue of entries between front and back end.
// Depends on gbfb_pkg. DEPTH is a power of two, at least 2.
`timescale 1ns / 1ps
`default_nettype none

module gbfb_queue
    import gbfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output logic        empty,
    output logic        full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == CNT_W'(DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/gbfb_back.sv
// Back end: expands queue entries into frame bytes, one per cycle while the
// output is not stalled, into a registered output stage. Depends on gbfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbfb_back
    import gbfb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t head,
    input  wire logic   q_empty,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [7:0]  out_byte,
    output logic        out_eof
);

    logic [2:0] step_reg, step_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_eof_reg;

    logic       out_free;
    logic       at_last;
    logic [2:0] last_step;
    logic [7:0] sel_byte;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sel_byte  = 8'd0;
        last_step = 3'd0;
        unique case (head.kind)
            CMD_START:
            begin
                last_step = head.last ? 3'd7 : 3'd5;
                unique case (step_reg)
                    3'd0:    sel_byte = SYNC_ONE;
                    3'd1:    sel_byte = SYNC_TWO;
                    3'd2:    sel_byte = head.b0;
                    3'd3:    sel_byte = head.b1;
                    3'd4:    sel_byte = head.b2;
                    3'd5:    sel_byte = 8'd0;
                    3'd6:    sel_byte = head.ck_a;
                    default: sel_byte = head.ck_b;
                endcase
            end
            CMD_DATA:
            begin
                last_step = head.last ? 3'd2 : 3'd0;
                unique case (step_reg)
                    3'd0:    sel_byte = head.b0;
                    3'd1:    sel_byte = head.ck_a;
                    default: sel_byte = head.ck_b;
                endcase
            end
            default: ;
        endcase
    end

    assign at_last   = step_reg == last_step;
    assign pop       = out_free && !q_empty && at_last;
    assign step_next = at_last ? 3'd0 : step_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= !q_empty;
            if (!q_empty)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && !q_empty)
        begin
            out_byte_reg <= sel_byte;
            out_eof_reg  <= head.last && at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_eof   = out_eof_reg;

endmodule

`default_nettype wire

// File: hdl/gbfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
// Depends on gbfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gbfb_checker
    import gbfb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_eof
);

    logic       out_take;
    logic       expect_sync_reg;
    logic [7:0] count_reg;

    assign out_take = out_valid && out_ready;

    // After reset or a closed frame the next byte must be the first sync byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_sync_reg <= 1'b1;
            count_reg       <= 8'd0;
        end
        else if (out_take)
        begin
            expect_sync_reg <= out_eof;
            if (expect_sync_reg)
            begin
                count_reg <= 8'd1;
            end
            else if (count_reg != 8'hFF)
            begin
                count_reg <= count_reg + 8'd1;
            end
        end
    end

    `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(out_eof), "stalled byte changed")
    `ASSERT_SAME(a_frame_opens, out_valid && expect_sync_reg,
        out_byte == SYNC_ONE && !out_eof, "frame does not open with sync")
    `ASSERT_SAME(a_frame_length, out_valid && out_eof,
        !expect_sync_reg && count_reg >= 8'd7, "frame closed too early")

endmodule

bind gnss_binary_frame_builder_top gbfb_checker u_gbfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (stream.valid),
    .out_ready (stream.ready),
    .out_byte  (stream.out_byte),
    .out_eof   (stream.end_of_frame)
);

`default_nettype wire
